[rtl/apdc_pkg.sv]
// Shared constants and types for the asset pack directory checker.
// Holds pack format constants, default limits and the status codes.
// Used by rtl/asset_pack_directory_checker.sv.
package apdc_pkg;

  // Pack format constants
  localparam logic [31:0] PACK_MAGIC   = 32'h4B41_5048;
  localparam logic [31:0] PACK_VERSION = 32'd3;
  localparam int          HEADER_BYTES = 16;
  localparam logic [31:0] TEX_MAX_DIM  = 32'd8192;
  localparam logic [31:0] RATE_MIN     = 32'd4000;
  localparam logic [31:0] RATE_MAX     = 32'd192000;

  // Default limits
  localparam int DEF_MAX_ENTRIES = 100000;
  localparam int DEF_NAME_BYTES  = 56;

  // Entry kinds with size checks
  localparam logic [31:0] KIND_TEX_A   = 32'd1;
  localparam logic [31:0] KIND_TEX_B   = 32'd2;
  localparam logic [31:0] KIND_MONO    = 32'd3;
  localparam logic [31:0] KIND_STEREO  = 32'd4;

  // Verdict codes
  typedef enum logic [3:0] {
    ST_VALID       = 4'd0,
    ST_SHORT_FILE  = 4'd1,
    ST_MAGIC       = 4'd2,
    ST_VERSION     = 4'd3,
    ST_COUNT       = 4'd4,
    ST_DIR_PAST    = 4'd5,
    ST_NAME_UNTERM = 4'd6,
    ST_OVERLAP     = 4'd7,
    ST_SIZE_WRAP   = 4'd8,
    ST_PAST_END    = 4'd9,
    ST_ZERO_DIM    = 4'd10,
    ST_TOO_LARGE   = 4'd11,
    ST_TEX_SIZE    = 4'd12,
    ST_SAMPLE_RATE = 4'd13,
    ST_AUDIO_SIZE  = 4'd14
  } status_t;

endpackage

[rtl/asset_pack_directory_checker.sv]
// Asset pack directory checker: an accepted word's verdict is in the output register
// in the cycle after; throughput one word per cycle while the output is free or taken,
// set by the per-word update with entry checks split over the entry's last five words.
// The input stays ready while a verdict waits, as long as the sink takes it.
// Reset (rst, synchronous) clears file_size and leaves the block idle until a
// word marked first arrives.
// Depends on rtl/apdc_pkg.sv.
module asset_pack_directory_checker #(
  parameter int MAX_ENTRIES = apdc_pkg::DEF_MAX_ENTRIES,
  parameter int NAME_BYTES  = apdc_pkg::DEF_NAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: file size in bytes
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [63:0] cfg_tdata,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] word
  input  logic        s_tuser,   // [0] first
  // verdicts
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [3:0] status, [7:4] zero
);
  import apdc_pkg::*;

  // Derived geometry
  localparam int NAME_WORDS  = (NAME_BYTES + 3) / 4;
  localparam int ENTRY_WORDS = NAME_WORDS + 8;
  localparam int ENTRY_BYTES = ENTRY_WORDS * 4;
  localparam int PW          = $clog2(ENTRY_WORDS);
  localparam int CW          = $clog2(MAX_ENTRIES + 1);
  localparam int DIR_MAX     = HEADER_BYTES + MAX_ENTRIES * ENTRY_BYTES;
  localparam int DW          = $clog2(DIR_MAX + 1);

  // Header and entry word positions
  localparam logic [PW-1:0] HP_MAGIC   = PW'(0);
  localparam logic [PW-1:0] HP_VERSION = PW'(1);
  localparam logic [PW-1:0] HP_COUNT   = PW'(2);
  localparam logic [PW-1:0] HP_RSVD    = PW'(3);
  localparam logic [PW-1:0] EP_NAME0   = PW'(0);
  localparam logic [PW-1:0] EP_KIND    = PW'(NAME_WORDS);
  localparam logic [PW-1:0] EP_WIDTH   = PW'(NAME_WORDS + 1);
  localparam logic [PW-1:0] EP_HEIGHT  = PW'(NAME_WORDS + 2);
  localparam logic [PW-1:0] EP_MIPS    = PW'(NAME_WORDS + 3);
  localparam logic [PW-1:0] EP_OFF_LO  = PW'(NAME_WORDS + 4);
  localparam logic [PW-1:0] EP_OFF_HI  = PW'(NAME_WORDS + 5);
  localparam logic [PW-1:0] EP_SIZE_LO = PW'(NAME_WORDS + 6);

  // Control state
  logic [63:0]   file_size;
  logic [PW-1:0] word_position, word_position_next;
  logic          in_header, in_header_next;
  logic [CW-1:0] entries_left, entries_left_next;
  logic [DW-1:0] directory_bytes, directory_bytes_next;
  logic          verdict_given, verdict_given_next;
  logic          out_valid;
  status_t       out_status;

  // Per-entry payload state
  logic          name_has_nul, name_has_nul_next;
  logic          is_tex, is_tex_next;
  logic          is_aud, is_aud_next;
  logic          is_stereo, is_stereo_next;
  logic [31:0]   width_or_rate, width_or_rate_next;
  logic [31:0]   height_or_frames, height_or_frames_next;
  logic [31:0]   off_lo, off_lo_next;
  logic [31:0]   off_hi, off_hi_next;
  logic [31:0]   payload_size_low, payload_size_low_next;
  logic [31:0]   end_lo, end_lo_next;
  logic          end_carry, end_carry_next;
  logic          overlap, overlap_next;
  logic          tex_zero, tex_zero_next;
  logic          tex_big, tex_big_next;
  logic [27:0]   tex_prod, tex_prod_next;
  logic          rate_bad, rate_bad_next;

  // Step results
  logic          s_accept;
  logic          res_valid;
  status_t       res_status;
  logic [PW-1:0] cur_pos;
  logic          cur_hdr;
  logic [DW-1:0] dir_calc;
  logic          name_found;
  logic [32:0]   end_hi;
  logic [63:0]   end_full;
  logic [63:0]   size_full;
  logic [33:0]   aud_bytes;
  logic [CW-1:0] left_dec;

  assign s_accept   = s_tvalid && s_tready;
  assign s_tready   = !out_valid || m_tready;
  assign cfg_tready = 1'b1;
  assign m_tvalid   = out_valid;
  assign m_tdata    = {4'b0000, out_status};

  // Arithmetic shared by the header and the entry's last word
  assign cur_pos   = s_tuser ? HP_MAGIC : word_position;
  assign cur_hdr   = s_tuser || in_header;
  assign dir_calc  = DW'(HEADER_BYTES) + DW'(s_tdata[CW-1:0]) * DW'(ENTRY_BYTES);
  assign end_hi    = {1'b0, off_hi} + {1'b0, s_tdata} + {32'd0, end_carry};
  assign end_full  = {end_hi[31:0], end_lo};
  assign size_full = {s_tdata, payload_size_low};
  assign aud_bytes = is_stereo ? {height_or_frames, 2'b00} : {1'b0, height_or_frames, 1'b0};
  assign left_dec  = (entries_left != '0) ? entries_left - CW'(1) : entries_left;

  // Zero byte search over the name bytes of this word
  always_comb begin
    name_found = 1'b0;
    for (int b = 0; b < 4; b++) begin
      if ((int'(word_position) * 4 + b) < NAME_BYTES && s_tdata[8*b +: 8] == 8'h00) begin
        name_found = 1'b1;
      end
    end
  end

  // Per-word state update and verdict
  always_comb begin
    word_position_next    = word_position;
    in_header_next        = in_header;
    entries_left_next     = entries_left;
    directory_bytes_next  = directory_bytes;
    verdict_given_next    = verdict_given;
    name_has_nul_next     = name_has_nul;
    is_tex_next           = is_tex;
    is_aud_next           = is_aud;
    is_stereo_next        = is_stereo;
    width_or_rate_next    = width_or_rate;
    height_or_frames_next = height_or_frames;
    off_lo_next           = off_lo;
    off_hi_next           = off_hi;
    payload_size_low_next = payload_size_low;
    end_lo_next           = end_lo;
    end_carry_next        = end_carry;
    overlap_next          = overlap;
    tex_zero_next         = tex_zero;
    tex_big_next          = tex_big;
    tex_prod_next         = tex_prod;
    rate_bad_next         = rate_bad;
    res_valid             = 1'b0;
    res_status            = ST_VALID;

    // A word marked first restarts the pack
    if (s_tuser) begin
      verdict_given_next   = 1'b0;
      in_header_next       = 1'b1;
      word_position_next   = HP_MAGIC;
      entries_left_next    = '0;
      directory_bytes_next = '0;
      if (file_size < 64'(HEADER_BYTES)) begin
        res_valid          = 1'b1;
        res_status         = ST_SHORT_FILE;
        verdict_given_next = 1'b1;
      end
    end

    if (!verdict_given_next) begin
      if (cur_hdr) begin
        // Header words
        if (cur_pos == HP_MAGIC) begin
          if (s_tdata != PACK_MAGIC) begin
            res_valid = 1'b1;
            res_status = ST_MAGIC;
          end else begin
            word_position_next = HP_VERSION;
          end
        end else if (cur_pos == HP_VERSION) begin
          if (s_tdata != PACK_VERSION) begin
            res_valid = 1'b1;
            res_status = ST_VERSION;
          end else begin
            word_position_next = HP_COUNT;
          end
        end else if (cur_pos == HP_COUNT) begin
          if (s_tdata > 32'(MAX_ENTRIES)) begin
            res_valid = 1'b1;
            res_status = ST_COUNT;
          end else begin
            directory_bytes_next = dir_calc;
            if ({{(64-DW){1'b0}}, dir_calc} > file_size) begin
              res_valid = 1'b1;
              res_status = ST_DIR_PAST;
            end else begin
              entries_left_next  = s_tdata[CW-1:0];
              word_position_next = HP_RSVD;
            end
          end
        end else begin
          in_header_next     = 1'b0;
          word_position_next = EP_NAME0;
          if (entries_left == '0) begin
            res_valid = 1'b1;
            res_status = ST_VALID;
          end
        end
      end else begin
        // Directory entry words
        word_position_next = word_position + PW'(1);
        if (word_position < EP_KIND) begin
          name_has_nul_next = (word_position == EP_NAME0) ? name_found
                                                          : (name_has_nul || name_found);
        end else if (word_position == EP_KIND) begin
          is_tex_next    = (s_tdata == KIND_TEX_A) || (s_tdata == KIND_TEX_B);
          is_aud_next    = (s_tdata == KIND_MONO) || (s_tdata == KIND_STEREO);
          is_stereo_next = (s_tdata == KIND_STEREO);
        end else if (word_position == EP_WIDTH) begin
          width_or_rate_next = s_tdata;
        end else if (word_position == EP_HEIGHT) begin
          height_or_frames_next = s_tdata;
        end else if (word_position == EP_MIPS) begin
          // dimension and rate checks from the stored words
          tex_zero_next = (width_or_rate == 32'd0) || (height_or_frames == 32'd0);
          tex_big_next  = (width_or_rate > TEX_MAX_DIM) || (height_or_frames > TEX_MAX_DIM);
          tex_prod_next = 28'(width_or_rate[13:0]) * 28'(height_or_frames[13:0]);
          rate_bad_next = (width_or_rate < RATE_MIN) || (width_or_rate > RATE_MAX);
        end else if (word_position == EP_OFF_LO) begin
          off_lo_next = s_tdata;
        end else if (word_position == EP_OFF_HI) begin
          off_hi_next  = s_tdata;
          overlap_next = {s_tdata, off_lo} < {{(64-DW){1'b0}}, directory_bytes};
        end else if (word_position == EP_SIZE_LO) begin
          payload_size_low_next         = s_tdata;
          {end_carry_next, end_lo_next} = {1'b0, off_lo} + {1'b0, s_tdata};
        end else begin
          // last word: verdict for this entry
          word_position_next = EP_NAME0;
          res_valid = 1'b1;
          if (!name_has_nul) begin
            res_status = ST_NAME_UNTERM;
          end else if (overlap) begin
            res_status = ST_OVERLAP;
          end else if (end_hi[32]) begin
            res_status = ST_SIZE_WRAP;
          end else if (end_full > file_size) begin
            res_status = ST_PAST_END;
          end else if (is_tex && tex_zero) begin
            res_status = ST_ZERO_DIM;
          end else if (is_tex && tex_big) begin
            res_status = ST_TOO_LARGE;
          end else if (is_tex && ({34'd0, tex_prod, 2'b00} != size_full)) begin
            res_status = ST_TEX_SIZE;
          end else if (is_aud && rate_bad) begin
            res_status = ST_SAMPLE_RATE;
          end else if (is_aud && ({30'd0, aud_bytes} != size_full)) begin
            res_status = ST_AUDIO_SIZE;
          end else begin
            entries_left_next = left_dec;
            res_valid = (left_dec == '0);
          end
        end
      end
      if (res_valid) begin
        verdict_given_next = 1'b1;
      end
    end
  end

  // Control registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      file_size       <= '0;
      word_position   <= '0;
      in_header       <= 1'b1;
      entries_left    <= '0;
      directory_bytes <= '0;
      verdict_given   <= 1'b1;
      out_valid       <= 1'b0;
      out_status      <= ST_VALID;
    end else begin
      if (cfg_tvalid && cfg_tready) begin
        file_size <= cfg_tdata;
      end
      if (s_accept) begin
        word_position   <= word_position_next;
        in_header       <= in_header_next;
        entries_left    <= entries_left_next;
        directory_bytes <= directory_bytes_next;
        verdict_given   <= verdict_given_next;
      end
      if (s_accept && res_valid) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Entry payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      name_has_nul     <= name_has_nul_next;
      is_tex           <= is_tex_next;
      is_aud           <= is_aud_next;
      is_stereo        <= is_stereo_next;
      width_or_rate    <= width_or_rate_next;
      height_or_frames <= height_or_frames_next;
      off_lo           <= off_lo_next;
      off_hi           <= off_hi_next;
      payload_size_low <= payload_size_low_next;
      end_lo           <= end_lo_next;
      end_carry        <= end_carry_next;
      overlap          <= overlap_next;
      tex_zero         <= tex_zero_next;
      tex_big          <= tex_big_next;
      tex_prod         <= tex_prod_next;
      rate_bad         <= rate_bad_next;
    end
  end

  // Checks on the control state
  a_no_result_while_idle: assert property (@(posedge clk) disable iff (rst)
    s_accept && verdict_given && !s_tuser |-> !res_valid)
    else $error("result produced while idle after a verdict");

  a_result_sets_verdict: assert property (@(posedge clk) disable iff (rst)
    s_accept && res_valid |=> verdict_given && out_valid)
    else $error("verdict not recorded after a result");

  a_header_position: assert property (@(posedge clk) disable iff (rst)
    in_header |-> word_position <= HP_RSVD)
    else $error("header position out of range");

  a_entries_pending: assert property (@(posedge clk) disable iff (rst)
    !in_header && !verdict_given |-> entries_left != '0)
    else $error("directory walk with no entries left");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_status))
    else $error("pending verdict lost or changed");

endmodule

[tb/asset_pack_directory_checker_tb.sv]
`timescale 1ns / 1ps
// Testbench for asset_pack_directory_checker: streams pack headers and directories,
// predicts each verdict and checks it against the block's status output.
// Depends on rtl/apdc_pkg.sv and rtl/asset_pack_directory_checker.sv.
module asset_pack_directory_checker_tb;
  import apdc_pkg::*;

  localparam int NAME_WORDS  = (DEF_NAME_BYTES + 3) / 4;
  localparam int ENTRY_WORDS = NAME_WORDS + 8;
  localparam int ENTRY_BYTES = ENTRY_WORDS * 4;
  localparam int WORD_TARGET = 1700;
  localparam int CALM_FROM   = 1450;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE      = 8;

  // Ways an entry is spoiled on purpose
  typedef enum int {
    FLAW_NONE, FLAW_NAME, FLAW_OVERLAP, FLAW_WRAP, FLAW_PAST_END,
    FLAW_ZERO_DIM, FLAW_TOO_LARGE, FLAW_SIZE, FLAW_RATE
  } flaw_e;

  // Tracks the pack parser state and queues the verdicts it should give
  class verdict_board;
    logic [63:0] file_size;
    int unsigned pos;
    bit          in_header;
    logic [31:0] entries_left;
    logic [63:0] dir_bytes;
    bit          name_nul;
    logic [31:0] kind, dim_a, dim_b;
    logic [63:0] pay_off;
    logic [31:0] size_lo;
    bit          verdict_done;
    status_t     expected_q[$];
    int          errors, words_used, verdicts_seen;
    int          code_hits[16];

    function new();
      file_size = '0; pos = 0; in_header = 1; entries_left = '0; dir_bytes = '0;
      name_nul = 0; kind = '0; dim_a = '0; dim_b = '0; pay_off = '0; size_lo = '0;
      verdict_done = 1; errors = 0; words_used = 0; verdicts_seen = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void issue(status_t st);
      verdict_done = 1;
      expected_q.push_back(st);
    endfunction

    // Entry checks in priority order, run on the entry's last word
    function status_t entry_status(logic [63:0] pay_size);
      logic [63:0] end_off;
      logic [63:0] ch;
      if (!name_nul) return ST_NAME_UNTERM;
      if (pay_off < dir_bytes) return ST_OVERLAP;
      end_off = pay_off + pay_size;
      if (end_off < pay_off) return ST_SIZE_WRAP;
      if (end_off > file_size) return ST_PAST_END;
      if (kind == KIND_TEX_A || kind == KIND_TEX_B) begin
        if (dim_a == '0 || dim_b == '0) return ST_ZERO_DIM;
        if (dim_a > TEX_MAX_DIM || dim_b > TEX_MAX_DIM) return ST_TOO_LARGE;
        if (64'(dim_a) * 64'(dim_b) * 64'd4 != pay_size) return ST_TEX_SIZE;
      end
      if (kind == KIND_MONO || kind == KIND_STEREO) begin
        ch = (kind == KIND_STEREO) ? 64'd2 : 64'd1;
        if (dim_a < RATE_MIN || dim_a > RATE_MAX) return ST_SAMPLE_RATE;
        if (64'(dim_b) * ch * 64'd2 != pay_size) return ST_AUDIO_SIZE;
      end
      return ST_VALID;
    endfunction

    // Accepted input word; returns 1 when the block examines it
    function bit note_word(logic [31:0] w, bit first);
      int unsigned p;
      int b;
      status_t st;
      if (first) begin
        verdict_done = 0; in_header = 1; pos = 0; entries_left = '0; dir_bytes = '0;
        if (file_size < 64'(HEADER_BYTES)) begin
          issue(ST_SHORT_FILE);
          words_used++;
          return 1;
        end
      end
      if (verdict_done) return 0;
      words_used++;
      p = pos;
      if (in_header) begin
        case (p)
          0: if (w != PACK_MAGIC) begin issue(ST_MAGIC); return 1; end
          1: if (w != PACK_VERSION) begin issue(ST_VERSION); return 1; end
          2: begin
            if (64'(w) > 64'(DEF_MAX_ENTRIES)) begin issue(ST_COUNT); return 1; end
            dir_bytes = 64'(HEADER_BYTES) + 64'(w) * 64'(ENTRY_BYTES);
            if (dir_bytes > file_size) begin issue(ST_DIR_PAST); return 1; end
            entries_left = w;
          end
          default: begin
            in_header = 0;
            pos = 0;
            if (entries_left == '0) issue(ST_VALID);
            return 1;
          end
        endcase
        pos = p + 1;
        return 1;
      end
      // Name words: look for a NUL byte within the name length
      if (p < NAME_WORDS) begin
        if (p == 0) name_nul = 0;
        for (b = 0; b < 4; b++)
          if (p * 4 + b < DEF_NAME_BYTES && w[8*b +: 8] == 8'h00) name_nul = 1;
        pos = p + 1;
        return 1;
      end
      case (p - NAME_WORDS)
        0: kind = w;
        1: dim_a = w;
        2: dim_b = w;
        3: ;
        4: pay_off[31:0] = w;
        5: pay_off[63:32] = w;
        6: size_lo = w;
        default: begin
          st = entry_status({w, size_lo});
          pos = 0;
          if (st != ST_VALID) begin issue(st); return 1; end
          if (entries_left > '0) entries_left--;
          if (entries_left == '0) issue(ST_VALID);
          return 1;
        end
      endcase
      pos = p + 1;
      return 1;
    endfunction

    function void check_verdict(logic [7:0] data);
      status_t want;
      verdicts_seen++;
      if (expected_q.size() == 0) begin
        $error("status: no verdict expected, got %0d", data[3:0]);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      code_hits[int'(want)]++;
      if (data[3:0] !== want) begin
        $error("status: expected %0d (%s), got %0d", want, want.name(), data[3:0]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_tvalid = 1'b0;
  logic        cfg_tready;
  logic [63:0] cfg_tdata  = '0;
  logic        s_tvalid   = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata    = '0;   // [31:0] word
  logic        s_tuser    = 1'b0; // [0] first
  logic        m_tvalid;
  logic        m_tready   = 1'b0;
  logic [7:0]  m_tdata;           // [3:0] status, [7:4] zero

  verdict_board sb;
  bit           idle_on = 1'b1;
  logic [63:0]  cur_fs = '0;
  int           hold_left = 0;
  int           quiet = 0;
  int           packs_sent = 0;
  int           sizes_written = 0;
  int           words_sent = 0;

  asset_pack_directory_checker u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sink side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(0, 4);
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check every accepted verdict
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_verdict(m_tdata);
  end

  // Watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_tvalid && cfg_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One word request; valid stays high into the next call unless a gap is taken
  task automatic send_word(input logic [31:0] w, input logic first);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    void'(sb.note_word(w, first));
    words_sent++;
    idle_on = (words_sent < CALM_FROM);
  endtask

  // File size write, only once the block has drained
  task automatic set_file_size(input logic [63:0] fs);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= fs;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    sb.file_size = fs;
    cur_fs = fs;
    sizes_written++;
  endtask

  // One directory entry, mostly consistent, optionally spoiled and/or cut short
  task automatic send_entry(input logic [63:0] dir_end, input flaw_e flaw, input int cut);
    logic [31:0] ent [ENTRY_WORDS];
    logic [31:0] kind, dim_a, dim_b;
    logic [63:0] off, pay_size;
    int nul_at, wi, bi;
    case ($urandom_range(0, 6))
      0: kind = 32'd0;
      1: kind = KIND_TEX_A;
      2: kind = KIND_TEX_B;
      3: kind = KIND_MONO;
      4: kind = KIND_STEREO;
      5: kind = $urandom_range(5, 9);
      default: kind = $urandom;
    endcase
    if (kind == KIND_TEX_A || kind == KIND_TEX_B) begin
      dim_a = ($urandom_range(0, 7) == 0) ? TEX_MAX_DIM : 32'($urandom_range(1, 64));
      dim_b = ($urandom_range(0, 7) == 0) ? TEX_MAX_DIM : 32'($urandom_range(1, 64));
      pay_size = 64'(dim_a) * 64'(dim_b) * 64'd4;
    end else if (kind == KIND_MONO || kind == KIND_STEREO) begin
      case ($urandom_range(0, 7))
        0: dim_a = RATE_MIN;
        1: dim_a = RATE_MAX;
        default: dim_a = $urandom_range(RATE_MIN, RATE_MAX);
      endcase
      dim_b = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 4096));
      pay_size = 64'(dim_b) * ((kind == KIND_STEREO) ? 64'd4 : 64'd2);
    end else begin
      dim_a = $urandom;
      dim_b = $urandom;
      pay_size = 64'($urandom_range(0, 4096));
    end
    off = dir_end + (($urandom_range(0, 7) == 0) ? 64'd0 : 64'($urandom_range(1, 4096)));
    nul_at = $urandom_range(0, DEF_NAME_BYTES - 1);
    case (flaw)
      FLAW_NAME: nul_at = -1;
      FLAW_OVERLAP: off = dir_end - 64'($urandom_range(1, HEADER_BYTES));
      FLAW_WRAP: begin
        off = {32'hFFFF_FFFF, 32'($urandom)};
        // either ends exactly at the top of the address space or wraps past it
        pay_size = $urandom_range(0, 1) ? ~off : {32'hFFFF_FFFF, 32'($urandom)};
      end
      FLAW_PAST_END: pay_size = cur_fs - off + 64'($urandom_range(0, 1));
      FLAW_ZERO_DIM: begin
        if ($urandom_range(0, 1)) dim_a = '0;
        else dim_b = '0;
        pay_size = 64'(dim_a) * 64'(dim_b) * 64'd4;
      end
      FLAW_TOO_LARGE: begin
        if ($urandom_range(0, 1)) dim_a = TEX_MAX_DIM + 32'd1;
        else dim_b = $urandom_range(32'hFFFF_FFFF, TEX_MAX_DIM + 32'd1);
        pay_size = 64'(dim_a) * 64'(dim_b) * 64'd4;
      end
      FLAW_SIZE: pay_size = pay_size ^ (64'd1 << $urandom_range(0, 63));
      FLAW_RATE: begin
        case ($urandom_range(0, 2))
          0: dim_a = RATE_MIN - 32'd1;
          1: dim_a = RATE_MAX + 32'd1;
          default: dim_a = $urandom;
        endcase
      end
      default: ;
    endcase
    // name bytes are nonzero except the chosen terminator
    for (wi = 0; wi < NAME_WORDS; wi++)
      for (bi = 0; bi < 4; bi++)
        ent[wi][8*bi +: 8] = (wi * 4 + bi == nul_at) ? 8'h00 : 8'($urandom_range(1, 255));
    ent[NAME_WORDS]     = kind;
    ent[NAME_WORDS + 1] = dim_a;
    ent[NAME_WORDS + 2] = dim_b;
    ent[NAME_WORDS + 3] = $urandom;
    ent[NAME_WORDS + 4] = off[31:0];
    ent[NAME_WORDS + 5] = off[63:32];
    ent[NAME_WORDS + 6] = pay_size[31:0];
    ent[NAME_WORDS + 7] = pay_size[63:32];
    for (wi = 0; wi < cut; wi++) send_word(ent[wi], 1'b0);
  endtask

  // Header plus a few entries; sometimes a bad header, a wrong count or a cut-off end
  task automatic send_pack();
    logic [31:0] cnt;
    logic [63:0] dir_end;
    int n, i, cut;
    flaw_e flaw;
    n = $urandom_range(0, 3);
    case ($urandom_range(0, 15))
      0: cnt = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                    : 32'(DEF_MAX_ENTRIES + $urandom_range(1, 1000));
      1: cnt = DEF_MAX_ENTRIES;
      2: cnt = n + 1;
      default: cnt = n;
    endcase
    packs_sent++;
    send_word(($urandom_range(0, 19) == 0) ? 32'($urandom) : PACK_MAGIC, 1'b1);
    send_word(($urandom_range(0, 19) == 0) ? 32'($urandom_range(0, 7)) : PACK_VERSION, 1'b0);
    send_word(cnt, 1'b0);
    send_word($urandom, 1'b0);
    dir_end = 64'(HEADER_BYTES) + 64'(cnt) * 64'(ENTRY_BYTES);
    for (i = 0; i < n; i++) begin
      flaw = ($urandom_range(0, 7) == 0) ? flaw_e'($urandom_range(FLAW_NAME, FLAW_RATE))
                                        : FLAW_NONE;
      cut = (i == n - 1 && $urandom_range(0, 14) == 0) ? $urandom_range(0, ENTRY_WORDS - 1)
                                                      : ENTRY_WORDS;
      send_entry(dir_end, flaw, cut);
    end
    // stray words after the verdict, or into an unfinished pack
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
  endtask

  initial begin
    int codes_seen;
    logic [63:0] fs;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle after reset, short file at reset size and just below the header
    send_word($urandom, 1'b0);
    send_word(PACK_MAGIC, 1'b1);
    set_file_size(64'd15);
    send_word(PACK_MAGIC, 1'b1);
    // Smallest legal file: empty directory passes, a one-entry directory runs past the end
    set_file_size(64'd16);
    send_word(PACK_MAGIC, 1'b1);
    send_word(PACK_VERSION, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(PACK_MAGIC, 1'b1);
    send_word(PACK_VERSION, 1'b0);
    send_word(32'd1, 1'b0);
    // Bad magic and bad version
    send_word(32'h0000_0000, 1'b1);
    send_word(PACK_MAGIC, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    // Largest file: count limits, and a restart in the middle of a header
    set_file_size(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(PACK_MAGIC, 1'b1);
    send_word(PACK_VERSION, 1'b0);
    send_word(32'(DEF_MAX_ENTRIES + 1), 1'b0);
    send_word(PACK_MAGIC, 1'b1);
    send_word(PACK_VERSION, 1'b0);
    send_word(PACK_MAGIC, 1'b1);
    send_word(PACK_VERSION, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);

    // Random phases, each with its own file size
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0: fs = 64'd0;
        1: fs = 64'd15;
        2: fs = 64'd16;
        3: fs = 64'(HEADER_BYTES + ENTRY_BYTES);
        4: fs = 64'hFFFF_FFFF_FFFF_FFFF;
        5: fs = {32'($urandom), 32'($urandom)};
        6: fs = 64'h1_0000_0000;
        default: fs = 64'd1 << 20;
      endcase
      set_file_size(fs);
      repeat ((fs < 64'(HEADER_BYTES)) ? 2 : 8) begin
        if (words_sent < WORD_TARGET) send_pack();
      end
    end

    // Drain and report
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    codes_seen = 0;
    foreach (sb.code_hits[i]) if (sb.code_hits[i] != 0) codes_seen++;
    $display("Streamed %0d packs over %0d file sizes, %0d words sent, %0d examined",
             packs_sent, sizes_written, words_sent, sb.words_used);
    $display("%0d verdicts checked, distinct status codes seen: %0d of 15",
             sb.verdicts_seen, codes_seen);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/apdc_pkg.sv
rtl/asset_pack_directory_checker.sv
tb/asset_pack_directory_checker_tb.sv
